// ===== hw/rtl/sgf_pkg.sv =====
// Shared constants, types and codes of the Savitzky-Golay smoothing filter.
package sgf_pkg;

    // Sizing
    localparam int MAX_HALF    = 15;
    localparam int SAMPLE_BITS = 16;
    localparam int TAP_BITS    = 24;
    localparam int FRAC_BITS   = 16;
    localparam int OUT_BITS    = 32;
    localparam int CFG_HALF_W  = 4;

    localparam int DEPTH    = 2 * MAX_HALF + 1;
    localparam int SEEN_CAP = DEPTH + 1;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int HALF_W   = $clog2(MAX_HALF + 1);
    localparam int SEEN_W   = $clog2(SEEN_CAP + 1);
    // signed width for mirrored index math (covers -2*SEEN_CAP .. 2*SEEN_CAP)
    localparam int SIDX_W   = $clog2(2 * SEEN_CAP) + 2;
    localparam int PROD_W   = SAMPLE_BITS + TAP_BITS;
    localparam int ACC_W    = PROD_W + $clog2(DEPTH);
    localparam int HCMP_W   = (HALF_W > CFG_HALF_W) ? HALF_W : CFG_HALF_W;

    // Stream packing
    localparam int IN_FIELDS_W = SAMPLE_BITS + ADDR_W + TAP_BITS;
    localparam int S_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

    // APB register map
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam logic [CFG_HALF_W-1:0] HALF_RESET = CFG_HALF_W'(2);

    // Item kinds carried on tuser
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TAP    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_RESULT,
        ST_SHORT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic issue;
        logic next_d;
        logic load_out;
        logic load_short;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic starts_filter;
        logic starts_short;
        logic j_last;
        logic pipe_empty;
        logic more;
        logic out_free;
    } status_t;

endpackage

// ===== hw/rtl/savitzky_golay_fir_mirror_edges_top.sv =====
// Top level of the Savitzky-Golay smoothing filter with mirrored record edges.
//
// Input stream (s_*): one request per item. tuser = 1 loads a coefficient tap,
// tuser = 0 carries a data sample; tlast marks the last sample of a record.
// Output stream (m_*): each result carries one filtered value on tdata, tlast on the
// final value of a record, tuser set on the single result of a too-short record.
// APB port: register 0 holds half_width (window of 2*half_width+1 taps).
//
// Sequence: a tap load is done on acceptance. A sample that yields an output
// passes through accept, MAC over the 2h+1 taps, drain and result
// (h = effective half width); the single shared multiply-accumulate and its
// read/multiply/add pipeline serve one output at a time. The last sample of a
// record yields h+1 outputs, each further one again going through MAC, drain and result.
// Reset clears the sample count, ring pointer, half_width (to 2) and output
// valid; tap and history stores keep whatever they hold until written.
// A stalled receiver holds the result in the output register; the block
// computes the next result meanwhile and waits only to hand it over.
module savitzky_golay_fir_mirror_edges_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // sample/tap requests
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [sgf_pkg::S_TDATA_W-1:0]        s_tdata,  // sample, tap_index, tap_value
    input  logic                                 s_tuser,  // kind
    input  logic                                 s_tlast,  // last_sample
    // results
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [sgf_pkg::M_TDATA_W-1:0]        m_tdata,  // value
    output logic                                 m_tuser,  // short_record
    output logic                                 m_tlast,  // last_result
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sgf_pkg::PADDR_W-1:0]          paddr,
    input  logic [sgf_pkg::PDATA_W-1:0]          pwdata,
    output logic [sgf_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready
);
    import sgf_pkg::*;

    logic [CFG_HALF_W-1:0] half_reg;
    logic [HALF_W-1:0]     half_eff;
    cmd_t                  cmd;
    status_t               status;

    // Configuration register: one register, writes at every address reach it, reads return it only at address 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= HALF_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            half_reg <= pwdata[CFG_HALF_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == '0) ? PDATA_W'(half_reg) : '0;

    // Effective half width: zero acts as one, clamp at the maximum
    always_comb
    begin
        if (half_reg == '0)
        begin
            half_eff = HALF_W'(1);
        end
        else if (HCMP_W'(half_reg) > HCMP_W'(MAX_HALF))
        begin
            half_eff = HALF_W'(MAX_HALF);
        end
        else
        begin
            half_eff = HALF_W'(half_reg);
        end
    end

    sgf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sgf_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .half     (half_eff),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== hw/rtl/sgf_ctrl.sv =====
// Sequencer: request intake, per-output tap loop, drain, result and short-record hand-off.
module sgf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  sgf_pkg::status_t status,
    output sgf_pkg::cmd_t    cmd
);
    import sgf_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    if (status.starts_filter)
                    begin
                        state_next = ST_MAC;
                    end
                    else if (status.starts_short)
                    begin
                        state_next = ST_SHORT;
                    end
                end
            end
            ST_MAC:
            begin
                cmd.issue = 1'b1;
                if (status.j_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.pipe_empty)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (status.more)
                    begin
                        cmd.next_d = 1'b1;
                        state_next = ST_MAC;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SHORT:
            begin
                if (status.out_free)
                begin
                    cmd.load_short = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/sgf_datapath.sv =====
// Tap and history stores, mirrored address generation, MAC pipeline, output register.
module sgf_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sgf_pkg::cmd_t                    cmd,
    input  logic [sgf_pkg::HALF_W-1:0]       half,
    input  logic [sgf_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             s_tuser,
    input  logic                             s_tlast,
    input  logic                             m_tready,
    output sgf_pkg::status_t                 status,
    output logic                             m_tvalid,
    output logic [sgf_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tlast,
    output logic                             m_tuser
);
    import sgf_pkg::*;

    localparam int Q_W = ACC_W + 1 - FRAC_BITS;
    localparam logic signed [ACC_W:0] RND_HALF =
        {{(ACC_W + 1 - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
    localparam logic signed [63:0] OUT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] OUT_MIN = -64'sh0000_0000_8000_0000;

    // Stores
    logic signed [TAP_BITS-1:0]    tap_mem  [DEPTH];
    logic signed [SAMPLE_BITS-1:0] hist_mem [DEPTH];

    // Record state
    logic [ADDR_W-1:0] wp_reg;
    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] c_reg;
    logic [ADDR_W-1:0] newest_reg;
    logic              flush_reg;
    logic [HALF_W-1:0] d_reg;
    logic [ADDR_W-1:0] j_reg;

    // MAC pipeline
    logic                          v1_reg;
    logic                          v2_reg;
    logic signed [TAP_BITS-1:0]    tap_rd_reg;
    logic signed [SAMPLE_BITS-1:0] smp_rd_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ACC_W-1:0]       acc_reg;

    // Output register
    logic                m_tvalid_reg;
    logic [OUT_BITS-1:0] m_value_reg;
    logic                m_tlast_reg;
    logic                m_tuser_reg;

    // Request fields
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic [ADDR_W-1:0]             in_tidx;
    logic signed [TAP_BITS-1:0]    in_tval;
    logic                          is_sample;

    assign in_sample = s_tdata[SAMPLE_BITS-1:0];
    assign in_tidx   = s_tdata[SAMPLE_BITS +: ADDR_W];
    assign in_tval   = s_tdata[SAMPLE_BITS + ADDR_W +: TAP_BITS];
    assign is_sample = (s_tuser == KIND_SAMPLE);

    // Sample count after this request and window readiness
    logic [SEEN_W-1:0] seen_inc;
    logic [SEEN_W-1:0] h_plus1;
    logic [ADDR_W-1:0] wp_inc;

    assign seen_inc = (seen_reg < SEEN_W'(SEEN_CAP)) ? seen_reg + SEEN_W'(1) : seen_reg;
    assign h_plus1  = SEEN_W'(half) + SEEN_W'(1);
    assign wp_inc   = (wp_reg == ADDR_W'(DEPTH - 1)) ? '0 : wp_reg + ADDR_W'(1);

    // Mirrored index -> ring position for tap j
    logic signed [SIDX_W-1:0] c_s;
    logic signed [SIDX_W-1:0] d_s;
    logic signed [SIDX_W-1:0] h_s;
    logic signed [SIDX_W-1:0] j_s;
    logic signed [SIDX_W-1:0] idx0;
    logic signed [SIDX_W-1:0] idx1;
    logic signed [SIDX_W-1:0] idx2;
    logic signed [SIDX_W-1:0] back;
    logic [ADDR_W-1:0]        back_cl;
    logic signed [ADDR_W:0]   pos_diff;
    logic [ADDR_W-1:0]        pos;

    assign c_s  = $signed(SIDX_W'(c_reg));
    assign d_s  = $signed(SIDX_W'(d_reg));
    assign h_s  = $signed(SIDX_W'(half));
    assign j_s  = $signed(SIDX_W'(j_reg));
    assign idx0 = c_s - d_s - h_s + j_s;
    assign idx1 = (idx0 < 0) ? -idx0 : idx0;
    assign idx2 = (flush_reg && (idx1 > c_s)) ? (c_s <<< 1) - idx1 : idx1;
    assign back = c_s - idx2;

    always_comb
    begin
        if (back < 0)
        begin
            back_cl = '0;
        end
        else if (back > $signed(SIDX_W'(DEPTH - 1)))
        begin
            back_cl = ADDR_W'(DEPTH - 1);
        end
        else
        begin
            back_cl = back[ADDR_W-1:0];
        end
    end

    assign pos_diff = $signed({1'b0, newest_reg}) - $signed({1'b0, back_cl});
    assign pos      = (pos_diff < 0) ? ADDR_W'(pos_diff + $signed((ADDR_W + 1)'(DEPTH)))
                                     : pos_diff[ADDR_W-1:0];

    // Store writes
    always_ff @(posedge clk)
    begin
        if (cmd.accept && !is_sample && (in_tidx < ADDR_W'(DEPTH)))
        begin
            tap_mem[in_tidx] <= in_tval;
        end
        if (cmd.accept && is_sample)
        begin
            hist_mem[wp_reg] <= in_sample;
        end
    end

    // Registered store reads and product
    always_ff @(posedge clk)
    begin
        tap_rd_reg <= tap_mem[j_reg];
        smp_rd_reg <= hist_mem[pos];
        prod_reg   <= tap_rd_reg * smp_rd_reg;
    end

    // Record control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            seen_reg <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            if (cmd.accept && is_sample)
            begin
                wp_reg   <= wp_inc;
                seen_reg <= s_tlast ? '0 : seen_inc;
            end
        end
    end

    // Per-output working registers and accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            c_reg      <= seen_inc - SEEN_W'(1);
            newest_reg <= wp_reg;
            flush_reg  <= s_tlast;
            d_reg      <= half;
            j_reg      <= '0;
            acc_reg    <= '0;
        end
        else if (cmd.next_d)
        begin
            d_reg   <= d_reg - HALF_W'(1);
            j_reg   <= '0;
            acc_reg <= '0;
        end
        else
        begin
            if (cmd.issue)
            begin
                j_reg <= j_reg + ADDR_W'(1);
            end
            if (v2_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    // Round half up, drop fraction, clamp to 32 bits
    logic signed [ACC_W:0] rnd;
    logic signed [Q_W-1:0] q;
    logic signed [63:0]    q64;
    logic [OUT_BITS-1:0]   value;

    assign rnd = (ACC_W + 1)'(acc_reg) + RND_HALF;
    assign q   = rnd[ACC_W:FRAC_BITS];
    assign q64 = 64'(q);

    always_comb
    begin
        if (q64 > OUT_MAX)
        begin
            value = OUT_MAX[OUT_BITS-1:0];
        end
        else if (q64 < OUT_MIN)
        begin
            value = OUT_MIN[OUT_BITS-1:0];
        end
        else
        begin
            value = q64[OUT_BITS-1:0];
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load_out || cmd.load_short)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            m_value_reg <= value;
            m_tlast_reg <= flush_reg && (d_reg == '0);
            m_tuser_reg <= 1'b0;
        end
        else if (cmd.load_short)
        begin
            m_value_reg <= '0;
            m_tlast_reg <= 1'b1;
            m_tuser_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_value_reg);
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // Status
    assign status.starts_filter = is_sample && (seen_inc >= h_plus1);
    assign status.starts_short  = is_sample && s_tlast && (seen_inc < h_plus1);
    assign status.j_last        = (j_reg == ADDR_W'({half, 1'b0}));
    assign status.pipe_empty    = !v1_reg && !v2_reg;
    assign status.more          = flush_reg && (d_reg != '0);
    assign status.out_free      = !m_tvalid_reg || m_tready;

endmodule

// ===== hw/rtl/sgf_checker.sv =====
// Port-level checks of the Savitzky-Golay filter, bound to the top level.
module sgf_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic                                 s_tuser,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [sgf_pkg::M_TDATA_W-1:0]        m_tdata,
    input logic                                 m_tuser,
    input logic                                 m_tlast
);
    import sgf_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // A short-record result is the final one of its record
    a_short_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("short-record result without last flag");

    // A short-record result carries a zero value
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata == '0))
        else $error("short-record result with nonzero value");

    // A tap load leaves the block ready for the next request
    a_tap_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == KIND_TAP) |=> s_tready)
        else $error("not ready after tap load");

endmodule

bind savitzky_golay_fir_mirror_edges_top sgf_checker u_sgf_checker (.*);
